// ===== sv/wffp_pkg.sv =====
// wffp_pkg: shared constants and types for the wheel feedback frame parser
// used by wffp_frame_check and wheel_feedback_frame_parser_core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wffp_pkg;

  localparam int unsigned FRAME_LEN = 8;
  localparam int unsigned FreshW    = $clog2(FRAME_LEN + 1);

  typedef logic [FRAME_LEN-1:0][7:0] window_t;

  typedef struct packed {
    logic               match;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic [7:0]         status_first;
    logic [7:0]         status_second;
  } frame_t;

endpackage

`default_nettype wire

// ===== sv/wffp_frame_check.sv =====
// wffp_frame_check: head, freshness and additive checksum test on one byte window
// plus field extraction; depends on wffp_pkg
`timescale 1ns / 1ps
`default_nettype none

module wffp_frame_check (
  input  wire wffp_pkg::window_t              window_i,
  input  wire logic [7:0]                     head_byte_i,
  input  wire logic [wffp_pkg::FreshW-1:0]    fresh_i,
  output wffp_pkg::frame_t                    frame_o
);

  logic [7:0] sum;

  always_comb begin
    sum = 8'd0;
    for (int k = 0; k < wffp_pkg::FRAME_LEN - 1; k++) begin
      sum = sum + window_i[k];
    end
  end

  always_comb begin
    frame_o.match = (fresh_i == wffp_pkg::FreshW'(wffp_pkg::FRAME_LEN)) &&
                    (window_i[0] == head_byte_i) &&
                    (sum == window_i[wffp_pkg::FRAME_LEN-1]);
    // speeds are sent high byte first
    frame_o.left_speed    = $signed({window_i[1], window_i[2]});
    frame_o.right_speed   = $signed({window_i[3], window_i[4]});
    frame_o.status_first  = window_i[5];
    frame_o.status_second = window_i[6];
  end

endmodule

`default_nettype wire

// ===== sv/wheel_feedback_frame_parser_core.sv =====
// wheel_feedback_frame_parser_core: top level of the wheel feedback frame parser
// depends on wffp_pkg and wffp_frame_check
//
// usage
//   input channel: one received serial byte per transfer (in_valid_i / in_ready_o)
//   output channel: one decoded frame per transfer (out_valid_o / out_ready_i),
//     left and right speed as signed 16-bit values, then two status bytes
//   cfg_we_i writes head_byte from cfg_wdata_i; write only while idle
//   a byte is taken in every cycle while the output register is empty or
//     being drained, so throughput is one byte per cycle
//   latency: a frame completed by a byte shows on the output one cycle after
//     that byte's transfer; the whole check runs between the byte window and
//     the output register in one cycle (adder chain over FRAME_LEN-1 bytes)
//   bytes that complete no frame give no output
//   a stall on the output holds the frame and stops input only while it waits
//   reset clears the window, the freshness count, head_byte and the output valid;
//     no frame can be reported until FRAME_LEN bytes have arrived
`timescale 1ns / 1ps
`default_nettype none

module wheel_feedback_frame_parser_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         byte_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      left_speed_o,
  output logic signed [15:0]      right_speed_o,
  output logic [7:0]              status_first_o,
  output logic [7:0]              status_second_o
);

  localparam logic [wffp_pkg::FreshW-1:0] FreshFull = wffp_pkg::FreshW'(wffp_pkg::FRAME_LEN);

  logic [7:0]                  head_q;
  wffp_pkg::window_t           window_q, window_d;
  logic [wffp_pkg::FreshW-1:0] fresh_q, fresh_inc, fresh_d;
  wffp_pkg::frame_t            frame;
  logic                        out_valid_q;
  wffp_pkg::frame_t            out_q;
  logic                        in_xfer;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // window and freshness count after this byte slides in, oldest byte at index 0
  always_comb begin
    for (int k = 0; k < wffp_pkg::FRAME_LEN - 1; k++) begin
      window_d[k] = window_q[k+1];
    end
    window_d[wffp_pkg::FRAME_LEN-1] = byte_in_i;
    fresh_inc = (fresh_q < FreshFull) ? fresh_q + 1'b1 : fresh_q;
    fresh_d   = frame.match ? '0 : fresh_inc;
  end

  wffp_frame_check u_check (
    .window_i    (window_d),
    .head_byte_i (head_q),
    .fresh_i     (fresh_inc),
    .frame_o     (frame)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= 8'd0;
      window_q    <= '0;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        head_q <= cfg_wdata_i;
      end
      if (in_xfer) begin
        window_q    <= window_d;
        fresh_q     <= fresh_d;
        out_valid_q <= frame.match;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && frame.match) begin
      out_q <= frame;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign left_speed_o    = out_q.left_speed;
  assign right_speed_o   = out_q.right_speed;
  assign status_first_o  = out_q.status_first;
  assign status_second_o = out_q.status_second;

`ifndef SYNTH
  a_out_from_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_xfer))
    else $error("output valid rose without an input transfer");

  a_fresh_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && frame.match) |=> (fresh_q == '0))
    else $error("freshness count not restarted after a frame");

  a_fresh_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= FreshFull)
    else $error("freshness count beyond frame length");

  a_no_match_early : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fresh_q < FreshFull - 1'b1) |-> !frame.match)
    else $error("frame matched before window was fresh");
`endif

endmodule

`default_nettype wire
